// ===== src/rcfd_pkg.sv =====
// Shared constants and types for the RC channel frame decoder.
// No dependencies; imported by rc_channel_frame_decoder_top.
package rcfd_pkg;

    localparam int FRAME_BYTES = 32;           // 6..64
    localparam int MAX_CH      = 14;
    localparam int NUM_CH_RAW  = (FRAME_BYTES - 4) / 2;
    localparam int NUM_CH      = (NUM_CH_RAW > MAX_CH) ? MAX_CH : NUM_CH_RAW;

    localparam int POS_W = 6;
    localparam int CH_W  = 4;

    localparam logic [7:0]       HDR0      = 8'h20;
    localparam logic [7:0]       HDR1      = 8'h40;
    localparam logic [15:0]      SUM_INIT  = 16'hFFFF;
    localparam logic [15:0]      SUM_HDR   = SUM_INIT - 16'(HDR0) - 16'(HDR1);
    localparam logic [POS_W-1:0] POS_BODY0 = POS_W'(2);
    localparam logic [POS_W-1:0] POS_SUM_LO = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] POS_SUM_HI = POS_W'(FRAME_BYTES - 1);
    localparam logic [CH_W-1:0]  CH_LAST   = CH_W'(NUM_CH - 1);
    localparam logic [POS_W-1:0] CH_LIMIT  = POS_W'(MAX_CH);

    typedef enum logic [4:0] {
        ST_HUNT = 5'b00001,
        ST_HDR1 = 5'b00010,
        ST_BODY = 5'b00100,
        ST_RD   = 5'b01000,
        ST_LOAD = 5'b10000
    } state_t;

endpackage

// ===== src/rc_channel_frame_decoder_top.sv =====
// RC servo frame decoder (header hunt, checksum, channel store, drain); needs rcfd_pkg.
// An error beat is registered when the final frame byte is taken; channel beats pass
// through ST_RD (store read), ST_LOAD and the output register while m_ready stays high.
// Throughput: 1 byte per cycle in a frame, the final byte waiting for a free output register;
// after a good frame no byte is taken while the store's single read port drains its channels.
// Reset: sync, active low: hunting, checksum 0xFFFF; store kept, each emitted word is fresh.
module rc_channel_frame_decoder_top
    import rcfd_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_rx_byte,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [CH_W-1:0] m_channel_index,
    output logic [15:0]     m_channel_value,
    output logic            m_frame_error,
    output logic            m_last_of_frame
);

    // Control state
    state_t            state_reg,  state_next;
    logic [POS_W-1:0]  pos_reg,    pos_next;
    logic [15:0]       sum_reg,    sum_next;
    logic [7:0]        low_reg,    low_next;
    logic [CH_W-1:0]   rd_idx_reg, rd_idx_next;

    // Output register (one beat)
    logic              out_valid_reg, out_valid_next;
    logic [CH_W-1:0]   out_idx_reg,   out_idx_next;
    logic [15:0]       out_val_reg,   out_val_next;
    logic              out_err_reg,   out_err_next;
    logic              out_last_reg,  out_last_next;

    // Channel store: one write port (body bytes), one registered read port (drain).
    // Writes happen only in ST_BODY and reads only in ST_RD, so accesses never overlap.
    logic [15:0]       ch_mem [MAX_CH];
    logic [15:0]       rd_data_reg;
    logic              mem_we;
    logic [CH_W-1:0]   mem_waddr;
    logic [POS_W-1:0]  ch_pos;

    logic              accept;
    logic              out_free;
    logic [15:0]       rx_sum;

    assign out_free = !out_valid_reg || m_ready;

    // Bytes are taken in the three receive states. The final frame byte may emit an
    // error beat at once, so it also waits for a free output register.
    always_comb begin
        case (state_reg)
            ST_HUNT, ST_HDR1: s_ready = 1'b1;
            ST_BODY:          s_ready = (pos_reg != POS_SUM_HI) || out_free;
            default:          s_ready = 1'b0;
        endcase
    end

    assign accept = s_valid && s_ready;
    assign rx_sum = {s_rx_byte, low_reg};

    // Odd payload position p holds the high byte of channel (p-3)/2
    assign ch_pos    = (pos_reg - POS_W'(3)) >> 1;
    assign mem_waddr = ch_pos[CH_W-1:0];
    assign mem_we    = accept && (state_reg == ST_BODY) && (pos_reg < POS_SUM_LO)
                       && pos_reg[0] && (ch_pos < CH_LIMIT);

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        low_next       = low_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_idx_next   = out_idx_reg;
        out_val_next   = out_val_reg;
        out_err_next   = out_err_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_HUNT: begin
                if (accept && (s_rx_byte == HDR0)) begin
                    state_next = ST_HDR1;
                end
            end
            ST_HDR1: begin
                if (accept) begin
                    if (s_rx_byte == HDR1) begin
                        state_next = ST_BODY;
                        pos_next   = POS_BODY0;
                        sum_next   = SUM_HDR;
                    end else if (s_rx_byte != HDR0) begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_BODY: begin
                if (accept) begin
                    pos_next = pos_reg + POS_W'(1);
                    if (pos_reg < POS_SUM_LO) begin
                        sum_next = sum_reg - {8'h00, s_rx_byte};
                        if (!pos_reg[0]) begin
                            low_next = s_rx_byte;
                        end
                    end else if (pos_reg == POS_SUM_LO) begin
                        low_next = s_rx_byte;
                    end else begin
                        // Final byte: compare and wrap up the frame
                        pos_next = '0;
                        sum_next = SUM_INIT;
                        low_next = '0;
                        if (rx_sum == sum_reg) begin
                            state_next  = ST_RD;
                            rd_idx_next = '0;
                        end else begin
                            state_next     = ST_HUNT;
                            out_valid_next = 1'b1;
                            out_idx_next   = '0;
                            out_val_next   = '0;
                            out_err_next   = 1'b1;
                            out_last_next  = 1'b1;
                        end
                    end
                end
            end
            ST_RD: begin
                state_next = ST_LOAD;   // read issued this cycle
            end
            ST_LOAD: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_idx_next   = rd_idx_reg;
                    out_val_next   = rd_data_reg;
                    out_err_next   = 1'b0;
                    out_last_next  = (rd_idx_reg == CH_LAST);
                    if (rd_idx_reg == CH_LAST) begin
                        state_next = ST_HUNT;
                    end else begin
                        state_next  = ST_RD;
                        rd_idx_next = rd_idx_reg + CH_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_HUNT;
            pos_reg       <= '0;
            sum_reg       <= SUM_INIT;
            low_reg       <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            low_reg       <= low_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, no reset needed
    always_ff @(posedge aclk) begin
        out_idx_reg  <= out_idx_next;
        out_val_reg  <= out_val_next;
        out_err_reg  <= out_err_next;
        out_last_reg <= out_last_next;
    end

    // Channel store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ch_mem[mem_waddr] <= {s_rx_byte, low_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RD) begin
            rd_data_reg <= ch_mem[rd_idx_reg];
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_channel_index = out_idx_reg;
    assign m_channel_value = out_val_reg;
    assign m_frame_error   = out_err_reg;
    assign m_last_of_frame = out_last_reg;

    // Error beat is always index 0 and closes its frame
    a_err_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_err_reg) |-> (out_last_reg && (out_idx_reg == '0)))
        else $error("error beat with bad index or last flag");

    // Drain index stays inside the emitted channel range
    a_rd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_RD) || (state_reg == ST_LOAD)) |-> (rd_idx_reg <= CH_LAST))
        else $error("drain index out of range");

    // Store is written only while collecting payload, never during drain
    a_we_body: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> ((state_reg == ST_BODY) && (pos_reg >= POS_BODY0 + POS_W'(1))))
        else $error("channel store written outside frame payload");

    // Read data is ready in ST_LOAD, the cycle after the read was issued
    a_rd_then_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD) |=> (state_reg == ST_LOAD))
        else $error("read not followed by load");

    // Body position never leaves the frame
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BODY) |-> ((pos_reg >= POS_BODY0) && (pos_reg <= POS_SUM_HI)))
        else $error("byte position outside frame");

endmodule
